### hdl/tlb2_pkg.sv
`timescale 1ns / 1ps
// Shared constants, line types and the address helper for the two-level TLB core.
package tlb2_pkg;

    localparam int L1_INDEX_BITS = 4;
    localparam int L2_INDEX_BITS = 6;
    localparam int OFFSET_BITS   = 12;

    localparam int VPN_W    = 36;
    localparam int OFF_W    = 12;
    localparam int PAGE_W   = 20;
    localparam int ADDR_W   = 32;

    localparam int L1_LINES = 1 << L1_INDEX_BITS;
    localparam int L2_LINES = 1 << L2_INDEX_BITS;
    localparam int L1_TAG_W = VPN_W - L1_INDEX_BITS;
    localparam int L2_TAG_W = VPN_W - L2_INDEX_BITS;

    localparam logic OP_TRANSLATE = 1'b0;
    localparam logic OP_FLUSH     = 1'b1;
    localparam logic KIND_INSTR   = 1'b0;
    localparam logic KIND_DATA    = 1'b1;

    typedef logic [VPN_W-1:0]         vpn_t;
    typedef logic [PAGE_W-1:0]        page_t;
    typedef logic [ADDR_W-1:0]        addr_t;
    typedef logic [L1_INDEX_BITS-1:0] l1_idx_t;
    typedef logic [L2_INDEX_BITS-1:0] l2_idx_t;
    typedef logic [L1_TAG_W-1:0]      l1_tag_t;
    typedef logic [L2_TAG_W-1:0]      l2_tag_t;

    typedef struct packed {
        l1_tag_t tag;
        page_t   page;
    } l1_line_t;

    typedef struct packed {
        l2_tag_t tag;
        page_t   page;
    } l2_line_t;

    // Physical address: page above the in-page offset, kept to the address width.
    function automatic addr_t make_addr(input page_t page, input logic [OFF_W-1:0] off);
        logic [OFFSET_BITS-1:0]        off_cut;
        logic [PAGE_W+OFFSET_BITS-1:0] full;
        begin
            off_cut = OFFSET_BITS'(off);
            full    = {page, off_cut};
            return ADDR_W'(full);
        end
    endfunction

endpackage

### hdl/two_level_tlb_lookup_refill_core.sv
`timescale 1ns / 1ps
// Two-level direct-mapped TLB core: L1 instruction/data lookup, shared L2, refill and flush.
//
//  channel  | ports                                                   | handshake
//  ---------+---------------------------------------------------------+---------------------------
//  request  | operation, access_kind, virt_page, byte_offset,         | transfer when start && !busy
//           | walked_page                                             |
//  result   | hit, phys_addr                                          | transfer when done (1 cycle)
//
//  One request per cycle, sustained. After a request transfer, the request and the
//  table reads are registered; the compare, the table update and the result register
//  follow, and the result is shown from the result register.
//  busy is never raised: the tables are written in the same cycle they are checked,
//  and the read ports forward a write to the same line, so back-to-back requests
//  always see the effects of the request before them.
//  Reset clears all valid bits (the flush state) and the pipeline; no clearing pass.
//  The receiver cannot stall: each result is shown for exactly one cycle.
module two_level_tlb_lookup_refill_core
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic                             operation,
    input  logic                             access_kind,
    input  logic [tlb2_pkg::VPN_W-1:0]       virt_page,
    input  logic [tlb2_pkg::OFF_W-1:0]       byte_offset,
    input  logic [tlb2_pkg::PAGE_W-1:0]      walked_page,
    output logic                             done,
    output logic                             hit,
    output logic [tlb2_pkg::ADDR_W-1:0]      phys_addr
);

    // ------------------------------------------------------------------
    // Request register (stage 1)
    // ------------------------------------------------------------------
    logic                  accept;
    logic                  s1_valid_reg;
    logic                  s1_op_reg;
    logic                  s1_kind_reg;
    tlb2_pkg::vpn_t        s1_vpn_reg;
    logic [tlb2_pkg::OFF_W-1:0] s1_off_reg;
    tlb2_pkg::page_t       s1_walked_reg;

    // Table storage: tag/page in memories, valid bits in flops so a flush clears every line together.
    tlb2_pkg::l1_line_t    i_mem [tlb2_pkg::L1_LINES];
    tlb2_pkg::l1_line_t    d_mem [tlb2_pkg::L1_LINES];
    tlb2_pkg::l2_line_t    l2_mem [tlb2_pkg::L2_LINES];
    tlb2_pkg::l1_line_t    i_rd_reg;
    tlb2_pkg::l1_line_t    d_rd_reg;
    tlb2_pkg::l2_line_t    l2_rd_reg;

    logic [tlb2_pkg::L1_LINES-1:0] i_valid_reg, i_valid_next;
    logic [tlb2_pkg::L1_LINES-1:0] d_valid_reg, d_valid_next;
    logic [tlb2_pkg::L2_LINES-1:0] l2_valid_reg, l2_valid_next;

    // Result register
    logic                  done_reg;
    logic                  hit_reg, hit_next;
    tlb2_pkg::addr_t       phys_addr_reg, phys_addr_next;

    // Stage-1 decode
    tlb2_pkg::l1_idx_t     rd_l1_idx;
    tlb2_pkg::l2_idx_t     rd_l2_idx;
    tlb2_pkg::l1_idx_t     s1_l1_idx;
    tlb2_pkg::l2_idx_t     s1_l2_idx;
    tlb2_pkg::l1_tag_t     s1_l1_tag;
    tlb2_pkg::l2_tag_t     s1_l2_tag;
    tlb2_pkg::l1_line_t    own_line;
    tlb2_pkg::l1_line_t    other_line;
    logic                  own_valid;
    logic                  l2_line_valid;
    logic                  l1_hit;
    logic                  l2_hit;
    logic                  translate;
    logic                  full_miss;
    tlb2_pkg::vpn_t        evict_vpn;
    tlb2_pkg::l1_tag_t     evict_l1_tag;
    logic                  evict_kill;

    // Table writes
    logic                  own_we;
    logic                  i_we;
    logic                  d_we;
    logic                  l2_we;
    tlb2_pkg::l1_line_t    l1_wdata;
    tlb2_pkg::l2_line_t    l2_wdata;

    // Never hold off a request: every conflict is resolved by write forwarding.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign rd_l1_idx = virt_page[tlb2_pkg::L1_INDEX_BITS-1:0];
    assign rd_l2_idx = virt_page[tlb2_pkg::L2_INDEX_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    // Payload: no reset needed.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg     <= operation;
            s1_kind_reg   <= access_kind;
            s1_vpn_reg    <= virt_page;
            s1_off_reg    <= byte_offset;
            s1_walked_reg <= walked_page;
        end
    end

    // ------------------------------------------------------------------
    // Memories: registered read, write-first on a same-line collision so the
    // next request sees this request's refill.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (i_we)
        begin
            i_mem[s1_l1_idx] <= l1_wdata;
        end
        if (i_we && (s1_l1_idx == rd_l1_idx))
        begin
            i_rd_reg <= l1_wdata;
        end
        else
        begin
            i_rd_reg <= i_mem[rd_l1_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (d_we)
        begin
            d_mem[s1_l1_idx] <= l1_wdata;
        end
        if (d_we && (s1_l1_idx == rd_l1_idx))
        begin
            d_rd_reg <= l1_wdata;
        end
        else
        begin
            d_rd_reg <= d_mem[rd_l1_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (l2_we)
        begin
            l2_mem[s1_l2_idx] <= l2_wdata;
        end
        if (l2_we && (s1_l2_idx == rd_l2_idx))
        begin
            l2_rd_reg <= l2_wdata;
        end
        else
        begin
            l2_rd_reg <= l2_mem[rd_l2_idx];
        end
    end

    // ------------------------------------------------------------------
    // Lookup and update decision
    // ------------------------------------------------------------------
    assign s1_l1_idx = s1_vpn_reg[tlb2_pkg::L1_INDEX_BITS-1:0];
    assign s1_l2_idx = s1_vpn_reg[tlb2_pkg::L2_INDEX_BITS-1:0];
    assign s1_l1_tag = s1_vpn_reg[tlb2_pkg::VPN_W-1:tlb2_pkg::L1_INDEX_BITS];
    assign s1_l2_tag = s1_vpn_reg[tlb2_pkg::VPN_W-1:tlb2_pkg::L2_INDEX_BITS];

    // Pick the L1 of this access kind; the other one is only checked on eviction.
    assign own_line   = (s1_kind_reg == tlb2_pkg::KIND_DATA) ? d_rd_reg : i_rd_reg;
    assign other_line = (s1_kind_reg == tlb2_pkg::KIND_DATA) ? i_rd_reg : d_rd_reg;
    assign own_valid  = (s1_kind_reg == tlb2_pkg::KIND_DATA) ? d_valid_reg[s1_l1_idx]
                                                             : i_valid_reg[s1_l1_idx];
    assign l2_line_valid = l2_valid_reg[s1_l2_idx];

    assign translate = s1_valid_reg && (s1_op_reg == tlb2_pkg::OP_TRANSLATE);
    assign l1_hit    = own_valid && (own_line.tag == s1_l1_tag);
    assign l2_hit    = l2_line_valid && (l2_rd_reg.tag == s1_l2_tag);
    assign full_miss = translate && !l1_hit && !l2_hit;

    // Rebuild the evicted page number from its L2 tag and line. Its L1 line is the
    // low index bits of the L2 line, i.e. the same L1 line this request reads, so
    // the other L1's read port already holds the entry to check. Its valid bit is
    // deliberately not consulted: clearing an invalid line changes nothing.
    assign evict_vpn    = {l2_rd_reg.tag, s1_l2_idx};
    assign evict_l1_tag = evict_vpn[tlb2_pkg::VPN_W-1:tlb2_pkg::L1_INDEX_BITS];
    assign evict_kill   = full_miss && l2_line_valid && (other_line.tag == evict_l1_tag);

    // Own L1 is refilled on an L2 hit or a full miss; L2 only on a full miss.
    assign own_we   = translate && !l1_hit;
    assign i_we     = own_we && (s1_kind_reg == tlb2_pkg::KIND_INSTR);
    assign d_we     = own_we && (s1_kind_reg == tlb2_pkg::KIND_DATA);
    assign l2_we    = full_miss;
    assign l1_wdata = '{tag: s1_l1_tag, page: (l2_hit ? l2_rd_reg.page : s1_walked_reg)};
    assign l2_wdata = '{tag: s1_l2_tag, page: s1_walked_reg};

    always_comb
    begin
        i_valid_next  = i_valid_reg;
        d_valid_next  = d_valid_reg;
        l2_valid_next = l2_valid_reg;
        if (s1_valid_reg && (s1_op_reg == tlb2_pkg::OP_FLUSH))
        begin
            i_valid_next  = '0;
            d_valid_next  = '0;
            l2_valid_next = '0;
        end
        else
        begin
            if (i_we)
            begin
                i_valid_next[s1_l1_idx] = 1'b1;
            end
            if (d_we)
            begin
                d_valid_next[s1_l1_idx] = 1'b1;
            end
            if (l2_we)
            begin
                l2_valid_next[s1_l2_idx] = 1'b1;
            end
            // Drop the stale copy in the other L1 (own and other never coincide).
            if (evict_kill && (s1_kind_reg == tlb2_pkg::KIND_DATA))
            begin
                i_valid_next[s1_l1_idx] = 1'b0;
            end
            if (evict_kill && (s1_kind_reg == tlb2_pkg::KIND_INSTR))
            begin
                d_valid_next[s1_l1_idx] = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_valid_reg  <= '0;
            d_valid_reg  <= '0;
            l2_valid_reg <= '0;
        end
        else
        begin
            i_valid_reg  <= i_valid_next;
            d_valid_reg  <= d_valid_next;
            l2_valid_reg <= l2_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_comb
    begin
        hit_next       = 1'b0;
        phys_addr_next = '0;
        if (translate)
        begin
            if (l1_hit)
            begin
                hit_next       = 1'b1;
                phys_addr_next = tlb2_pkg::make_addr(own_line.page, s1_off_reg);
            end
            else if (l2_hit)
            begin
                hit_next       = 1'b1;
                phys_addr_next = tlb2_pkg::make_addr(l2_rd_reg.page, s1_off_reg);
            end
            else
            begin
                phys_addr_next = tlb2_pkg::make_addr(s1_walked_reg, s1_off_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg       <= hit_next;
        phys_addr_reg <= phys_addr_next;
    end

    assign done      = done_reg;
    assign hit       = hit_reg;
    assign phys_addr = phys_addr_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // Every request transfer yields a result once it has passed the request and result registers.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##2 done)
        else $error("request transfer without result two cycles later");

    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |-> ##2 !done)
        else $error("result strobe without a request");

    // A flush empties all three tables and reports a zero result.
    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && (s1_op_reg == tlb2_pkg::OP_FLUSH)) |=>
        ((i_valid_reg == '0) && (d_valid_reg == '0) && (l2_valid_reg == '0)
         && done && !hit && (phys_addr == '0)))
        else $error("flush left a valid line or a nonzero result");

    // A full miss leaves the L2 line valid for the next request.
    a_refill_valid: assert property (@(posedge clk) disable iff (!rst_n)
        full_miss |=> l2_valid_reg[$past(s1_l2_idx)])
        else $error("full miss did not refill the L2 line");

endmodule
